// ===== hdl/fpa_pkg.sv =====
// Shared types, constants and the divider step for the Q24.8 fixed-point ALU.
`default_nettype none
package fpa_pkg;

   // Number of fraction bits in a raw operand.
   localparam int FracBits = 8;
   // One quotient bit per step over the magnitude of the shifted dividend.
   localparam int DivSteps = 32 + FracBits;
   // Added to a negative value before the shift so to_int truncates toward zero.
   localparam logic [31:0] ToIntBias = 32'((64'd1 << FracBits) - 64'd1);
   // Request queue between the front and the back.
   localparam int QueueDepth = 4;
   localparam int QPtrBits = 2;
   localparam int QCntBits = 3;

   typedef enum logic [4:0] {
      OpAdd     = 5'd0,
      OpSub     = 5'd1,
      OpMul     = 5'd2,
      OpDiv     = 5'd3,
      OpNeg     = 5'd4,
      OpInc     = 5'd5,
      OpDec     = 5'd6,
      OpMin     = 5'd7,
      OpMax     = 5'd8,
      OpGt      = 5'd9,
      OpLt      = 5'd10,
      OpGe      = 5'd11,
      OpLe      = 5'd12,
      OpEq      = 5'd13,
      OpNe      = 5'd14,
      OpFromInt = 5'd15,
      OpToInt   = 5'd16,
      OpNone    = 5'd31
   } op_type;

   localparam logic [4:0] OpLastCode = 5'd16;

   // A decoded request as it waits in the queue.
   typedef struct packed {
      op_type             op;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } item_type;

   // Contents of one stage of the execution pipeline.
   typedef struct packed {
      op_type                op;
      logic [31:0]           res;
      logic                  cmp;
      logic                  dz;
      logic                  neg;
      logic [31:0]           rem;
      logic [31:0]           quo;
      logic [31:0]           dsr;
      logic [DivSteps-1:0]   dvd;
   } stage_type;

   // One restoring division step: bring down a dividend bit, try the subtract.
   function automatic stage_type div_step(stage_type s);
      stage_type   n;
      logic [32:0] part;
      logic [32:0] diff;
      n    = s;
      part = {s.rem, s.dvd[DivSteps-1]};
      diff = part - {1'b0, s.dsr};
      n.dvd = {s.dvd[DivSteps-2:0], 1'b0};
      if (!diff[32]) begin
         n.rem = diff[31:0];
         n.quo = {s.quo[30:0], 1'b1};
      end else begin
         n.rem = part[31:0];
         n.quo = {s.quo[30:0], 1'b0};
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/fpa_front.sv =====
// Front end: accepts requests, decodes the operation code and pushes them to the queue.
`default_nettype none
module fpa_front (
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [4:0]        req_op,
   input  wire logic [31:0]       req_a,
   input  wire logic [31:0]       req_b,
   input  wire logic              q_full,
   output logic                   q_push,
   output fpa_pkg::item_type      q_item
);
   import fpa_pkg::*;

   // Take a request whenever the queue has room.
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Codes past the last operation collapse to a single no-op code.
   always_comb begin
      q_item.a = req_a;
      q_item.b = req_b;
      if (req_op <= OpLastCode) begin
         q_item.op = op_type'(req_op);
      end else begin
         q_item.op = OpNone;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fpa_queue.sv =====
// Short request queue that decouples the front end from the execution pipeline.
`default_nettype none
module fpa_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire fpa_pkg::item_type  push_item,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output fpa_pkg::item_type       head_item
);
   import fpa_pkg::*;

   item_type              mem_ff [QueueDepth];
   logic [QPtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntBits-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCntBits'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued requests.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCntBits'(QueueDepth)) else $error("queue count overflow");
`endif

endmodule
`default_nettype wire

// ===== hdl/fpa_back.sv =====
// Execution pipeline: all operations, a multiplier and a one-bit-per-stage divider.
`default_nettype none
module fpa_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire fpa_pkg::item_type  in_item,
   output logic                    in_take,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_res,
   output logic                    rsp_cmp,
   output logic                    rsp_dz
);
   import fpa_pkg::*;

   stage_type          st_ff  [DivSteps+1];
   stage_type          st_in  [DivSteps+1];
   logic               vld_ff [DivSteps+1];
   logic signed [63:0] prod_ff, prod_in;
   logic               out_vld_ff;
   logic [31:0]        out_res_ff, out_res_in;
   logic               out_cmp_ff, out_dz_ff;
   logic               adv;
   logic [31:0]        a_mag, b_mag;
   logic signed [31:0] a, b;

   // The whole pipeline moves when the output register is free or being taken.
   assign adv     = !out_vld_ff || rsp_ready;
   assign in_take = adv && in_valid;

   assign a = in_item.a;
   assign b = in_item.b;
   assign a_mag = a[31] ? 32'(-a) : a;
   assign b_mag = b[31] ? 32'(-b) : b;
   assign prod_in = a * b;

   // First stage: the simple operations and divider setup. Then the division
   // stages; the multiply result is taken from the product in the first one.
   always_comb begin
      st_in[0]     = '0;
      st_in[0].op  = in_item.op;
      st_in[0].neg = a[31] ^ b[31];
      st_in[0].dsr = b_mag;
      st_in[0].dvd = {a_mag, {FracBits{1'b0}}};
      unique case (in_item.op)
         OpAdd:     st_in[0].res = a + b;
         OpSub:     st_in[0].res = a - b;
         OpNeg:     st_in[0].res = -a;
         OpInc:     st_in[0].res = a + 32'sd1;
         OpDec:     st_in[0].res = a - 32'sd1;
         OpMin:     st_in[0].res = (a < b) ? a : b;
         OpMax:     st_in[0].res = (a > b) ? a : b;
         OpGt:      st_in[0].cmp = (a > b);
         OpLt:      st_in[0].cmp = (a < b);
         OpGe:      st_in[0].cmp = (a >= b);
         OpLe:      st_in[0].cmp = (a <= b);
         OpEq:      st_in[0].cmp = (a == b);
         OpNe:      st_in[0].cmp = (a != b);
         OpFromInt: st_in[0].res = a <<< FracBits;
         OpToInt:   st_in[0].res =
            32'($signed(a + (a[31] ? ToIntBias : 32'd0)) >>> FracBits);
         OpDiv:     st_in[0].dz  = (b == 32'sd0);
         default:   st_in[0].res = '0;
      endcase
      for (int k = 1; k <= DivSteps; k++) begin
         st_in[k] = div_step(st_ff[k-1]);
      end
      if (st_ff[0].op == OpMul) begin
         st_in[1].res = prod_ff[FracBits+31:FracBits];
      end
   end

   // Sign fix of the quotient and the divide-by-zero case.
   always_comb begin
      out_res_in = st_ff[DivSteps].res;
      if (st_ff[DivSteps].op == OpDiv) begin
         if (st_ff[DivSteps].dz) begin
            out_res_in = '0;
         end else if (st_ff[DivSteps].neg) begin
            out_res_in = -st_ff[DivSteps].quo;
         end else begin
            out_res_in = st_ff[DivSteps].quo;
         end
      end
   end

   // Valid bits of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DivSteps; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= DivSteps; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         out_vld_ff <= vld_ff[DivSteps];
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= DivSteps; k++) begin
            st_ff[k] <= st_in[k];
         end
         prod_ff    <= prod_in;
         out_res_ff <= out_res_in;
         out_cmp_ff <= st_ff[DivSteps].cmp;
         out_dz_ff  <= st_ff[DivSteps].dz;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_res   = out_res_ff;
   assign rsp_cmp   = out_cmp_ff;
   assign rsp_dz    = out_dz_ff;

`ifndef SYNTHESIS
   a_dz_not_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_dz && rsp_cmp)) else $error("divide error on a comparison");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dz) |-> (rsp_res == '0)) else $error("nonzero result on divide error");
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cmp) |-> (rsp_res == '0)) else $error("nonzero result on comparison");
`endif

endmodule
`default_nettype wire

// ===== hdl/fixed_point_alu_q24_8_unit.sv =====
// Top level of the signed Q24.8 fixed-point ALU.
// Each request carries an operation code and two raw 32-bit operands and yields one
// response. A new request is accepted every cycle while the queue has room; each
// response passes the queue, one setup stage, 40 divider stages of one quotient bit
// each and the output register, whatever the operation, so responses stay in order.
// The one-bit-per-stage divider chain sets the pipeline depth. A four-entry queue
// and the output register absorb requests while responses stall, until the queue fills.
`default_nettype none
module fixed_point_alu_q24_8_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // operation [4:0], operand_a [36:5], operand_b [68:37], zero fill above
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // result_value [31:0], compare_true [32], divide_by_zero [33], zero fill above
   output logic [39:0]      rsp_tdata
);
   import fpa_pkg::*;

   item_type    push_item, head_item;
   logic        q_full, q_push, head_valid, take;
   logic [31:0] res;
   logic        cmp, dz;

   fpa_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tdata[4:0]),
      .req_a      (req_tdata[36:5]),
      .req_b      (req_tdata[68:37]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   fpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (take),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .in_item   (head_item),
      .in_take   (take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (res),
      .rsp_cmp   (cmp),
      .rsp_dz    (dz)
   );

   // Pack the response fields.
   assign rsp_tdata = {6'd0, dz, cmp, res};

endmodule
`default_nettype wire
